// ===== rtl/rotary_dial_pulse_decoder_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef ROTARY_DIAL_PULSE_DECODER_MACROS_SVH
`define ROTARY_DIAL_PULSE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDPD_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rdpd assertion failed");

// Next-cycle implication, checked outside reset.
`define RDPD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rdpd assertion failed");

`endif

// ===== rtl/rdpd_pkg.sv =====
`timescale 1ns / 1ps
package rdpd_pkg;

  localparam int TIMER_BITS     = 16;
  localparam int REG_BITS       = 16;
  localparam int CMP_BITS       = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int COUNT_BITS     = 4;
  localparam int EVENT_BITS     = 2;

  localparam logic [COUNT_BITS-1:0] PULSE_LIMIT = COUNT_BITS'(10);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ACTIVE_HIGH = 3'd0,
    REG_DEBOUNCE    = 3'd1,
    REG_HANGUP      = 3'd2,
    REG_PULSE_MIN   = 3'd3,
    REG_PULSE_MAX   = 3'd4,
    REG_DIGIT_GAP   = 3'd5
  } reg_index_t;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE    = 2'd0,
    EV_PULSE   = 2'd1,
    EV_IGNORED = 2'd2
  } pulse_event_t;

  typedef logic [TIMER_BITS-1:0] age_t;
  typedef logic [REG_BITS-1:0]   ticks_t;

endpackage

// ===== rtl/rdpd_in_if.sv =====
`timescale 1ns / 1ps
interface rdpd_in_if;
  logic valid;
  logic ready;
  logic hook_level;

  modport source (output valid, output hook_level, input ready);
  modport sink   (input valid, input hook_level, output ready);
endinterface

// ===== rtl/rdpd_out_if.sv =====
`timescale 1ns / 1ps
interface rdpd_out_if;
  import rdpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  raw_off_hook;
  logic                  off_hook;
  logic [COUNT_BITS-1:0] pending_pulses;
  logic [EVENT_BITS-1:0] pulse_event;
  logic                  digit_done;
  logic [COUNT_BITS-1:0] digit;

  modport source (output valid, output raw_off_hook, output off_hook,
                  output pending_pulses, output pulse_event, output digit_done,
                  output digit, input ready);
  modport sink   (input valid, input raw_off_hook, input off_hook,
                  input pending_pulses, input pulse_event, input digit_done,
                  input digit, output ready);
endinterface

// ===== rtl/rotary_dial_pulse_decoder.sv =====
`timescale 1ns / 1ps
// Rotary dial pulse decoder: one hook sample in, one status transaction out.
// Results are registered: an accepted sample's status is valid in the cycle after acceptance.
// Throughput: 1 sample per cycle while the output register is empty or taken; it frees on the same edge it is taken.
// Reset (rst, synchronous, active high): handset on hook, all counters zero,
// registers back to their defaults, output register empty.
module rotary_dial_pulse_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rdpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rdpd_pkg::REG_BITS-1:0]        cfg_data,
  rdpd_in_if.sink                              dial_in,
  rdpd_out_if.source                           dial_out
);
  import rdpd_pkg::*;

  `include "rotary_dial_pulse_decoder_macros.svh"

  // configuration
  logic   active_high;
  ticks_t debounce_ticks, hangup_ticks, pulse_min_ticks, pulse_max_ticks, digit_gap_ticks;

  // decoder state
  logic                  last_raw, stable_level, reported_level, awaiting_return;
  logic [COUNT_BITS-1:0] pulse_counter;
  age_t                  raw_age, break_age, since_pulse;

  logic                  last_raw_next, stable_level_next, reported_level_next;
  logic                  awaiting_return_next;
  logic [COUNT_BITS-1:0] pulse_counter_next;
  age_t                  raw_age_next, break_age_next, since_pulse_next;

  logic                  raw;
  pulse_event_t          event_next;
  logic                  done_next;
  logic [COUNT_BITS-1:0] digit_next;

  logic out_valid;
  logic accept;

  assign dial_in.ready = !out_valid || dial_out.ready;
  assign accept        = dial_in.valid && dial_in.ready;
  assign dial_out.valid = out_valid;

  function automatic age_t age_inc(age_t a);
    return (a == '1) ? a : a + age_t'(1);
  endfunction

  function automatic logic age_ge(age_t a, ticks_t t);
    return CMP_BITS'(a) >= CMP_BITS'(t);
  endfunction

  function automatic logic age_le(age_t a, ticks_t t);
    return CMP_BITS'(a) <= CMP_BITS'(t);
  endfunction

  always_comb begin
    raw = active_high ? dial_in.hook_level : !dial_in.hook_level;

    last_raw_next        = raw;
    raw_age_next         = (raw != last_raw) ? '0 : age_inc(raw_age);
    break_age_next       = age_inc(break_age);
    since_pulse_next     = age_inc(since_pulse);
    stable_level_next    = stable_level;
    reported_level_next  = reported_level;
    awaiting_return_next = awaiting_return;
    pulse_counter_next   = pulse_counter;
    event_next           = EV_NONE;
    done_next            = 1'b0;
    digit_next           = '0;

    // debounced level change
    if (raw != stable_level && age_ge(raw_age_next, debounce_ticks)) begin
      stable_level_next = raw;
      if (!raw) begin
        if (reported_level) begin
          break_age_next       = '0;
          awaiting_return_next = 1'b1;
        end
      end else if (awaiting_return && reported_level) begin
        awaiting_return_next = 1'b0;
        if (age_ge(break_age_next, pulse_min_ticks) &&
            age_le(break_age_next, pulse_max_ticks)) begin
          if (pulse_counter < PULSE_LIMIT) begin
            pulse_counter_next = pulse_counter + COUNT_BITS'(1);
          end
          since_pulse_next = '0;
          event_next       = EV_PULSE;
        end else begin
          event_next = EV_IGNORED;
        end
      end else if (!reported_level) begin
        reported_level_next = 1'b1;
        pulse_counter_next  = '0;
      end
    end

    // long break: hang up
    if (awaiting_return_next && reported_level_next && !stable_level_next &&
        age_ge(break_age_next, hangup_ticks)) begin
      awaiting_return_next = 1'b0;
      pulse_counter_next   = '0;
      reported_level_next  = 1'b0;
    end

    // quiet line after the last pulse completes the digit
    if (pulse_counter_next != '0 && reported_level_next && stable_level_next &&
        !awaiting_return_next && age_ge(since_pulse_next, digit_gap_ticks)) begin
      digit_next         = (pulse_counter_next == PULSE_LIMIT) ? '0 : pulse_counter_next;
      done_next          = 1'b1;
      pulse_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high     <= 1'b0;
      debounce_ticks  <= REG_BITS'(10);
      hangup_ticks    <= REG_BITS'(500);
      pulse_min_ticks <= REG_BITS'(20);
      pulse_max_ticks <= REG_BITS'(120);
      digit_gap_ticks <= REG_BITS'(300);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_HIGH: active_high     <= cfg_data[0];
        REG_DEBOUNCE:    debounce_ticks  <= cfg_data;
        REG_HANGUP:      hangup_ticks    <= cfg_data;
        REG_PULSE_MIN:   pulse_min_ticks <= cfg_data;
        REG_PULSE_MAX:   pulse_max_ticks <= cfg_data;
        REG_DIGIT_GAP:   digit_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw        <= 1'b0;
      stable_level    <= 1'b0;
      reported_level  <= 1'b0;
      awaiting_return <= 1'b0;
      pulse_counter   <= '0;
      raw_age         <= '0;
      break_age       <= '0;
      since_pulse     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        last_raw        <= last_raw_next;
        stable_level    <= stable_level_next;
        reported_level  <= reported_level_next;
        awaiting_return <= awaiting_return_next;
        pulse_counter   <= pulse_counter_next;
        raw_age         <= raw_age_next;
        break_age       <= break_age_next;
        since_pulse     <= since_pulse_next;
        out_valid       <= 1'b1;
      end else if (dial_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded on each accepted sample
  always_ff @(posedge clk) begin
    if (accept) begin
      dial_out.raw_off_hook   <= raw;
      dial_out.off_hook       <= reported_level_next;
      dial_out.pending_pulses <= pulse_counter_next;
      dial_out.pulse_event    <= event_next;
      dial_out.digit_done     <= done_next;
      dial_out.digit          <= digit_next;
    end
  end

  `RDPD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, pulse_counter <= PULSE_LIMIT)
  `RDPD_ASSERT_NOW(a_on_hook_idle, clk, rst, !reported_level,
                   pulse_counter == '0 && !awaiting_return)
  `RDPD_ASSERT_NOW(a_digit_clears, clk, rst, out_valid && dial_out.digit_done,
                   dial_out.pending_pulses == '0 && dial_out.off_hook)
  `RDPD_ASSERT_NEXT(a_accept_fills, clk, rst, accept, out_valid)

endmodule

// ===== dv/rdpd_status_checker.sv =====
`timescale 1ns / 1ps
module rdpd_status_checker import rdpd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  ticks_t                    cfg_data,
  rdpd_in_if                        dial_in,
  rdpd_out_if                       dial_out,
  output int unsigned               fail_count,
  output int unsigned               results_due
);

  typedef struct packed {
    logic                  raw_off_hook;
    logic                  off_hook;
    logic [COUNT_BITS-1:0] pending_pulses;
    pulse_event_t          pulse_event;
    logic                  digit_done;
    logic [COUNT_BITS-1:0] digit;
  } dial_status_t;

  // Register copies
  logic   pol_high;
  ticks_t debounce_lim;
  ticks_t hangup_lim;
  ticks_t pulse_lo;
  ticks_t pulse_hi;
  ticks_t gap_lim;

  // Line state
  logic                  last_raw;
  logic                  stable_lvl;
  logic                  reported_lvl;
  logic                  in_break;
  logic [COUNT_BITS-1:0] pulses;
  age_t                  raw_age;
  age_t                  break_age;
  age_t                  quiet_age;

  dial_status_t status_q[$];
  int unsigned  results_seen;

  function automatic age_t bump(input age_t a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic string status_text(input dial_status_t s);
    return $sformatf("raw=%0d hook=%0d pending=%0d event=%0d done=%0d digit=%0d",
                     s.raw_off_hook, s.off_hook, s.pending_pulses, s.pulse_event,
                     s.digit_done, s.digit);
  endfunction

  // Advance the line state by one pin sample and return the status it produces.
  function automatic dial_status_t decode_tick(input logic pin);
    logic         raw;
    dial_status_t res;
    raw = pol_high ? pin : ~pin;
    res = '0;
    res.pulse_event = EV_NONE;

    if (raw != last_raw) begin
      last_raw = raw;
      raw_age = '0;
    end else begin
      raw_age = bump(raw_age);
    end
    break_age = bump(break_age);
    quiet_age = bump(quiet_age);

    if (raw != stable_lvl && raw_age >= debounce_lim) begin
      stable_lvl = raw;
      if (!stable_lvl) begin
        // time the break only while off hook
        if (reported_lvl) begin
          break_age = '0;
          in_break = 1'b1;
        end
      end else if (in_break && reported_lvl) begin
        in_break = 1'b0;
        if (break_age >= pulse_lo && break_age <= pulse_hi) begin
          if (pulses < PULSE_LIMIT) pulses = pulses + 1'b1;
          quiet_age = '0;
          res.pulse_event = EV_PULSE;
        end else begin
          res.pulse_event = EV_IGNORED;
        end
      end else if (!reported_lvl) begin
        reported_lvl = 1'b1;
        pulses = '0;
      end
    end

    if (in_break && reported_lvl && !stable_lvl && break_age >= hangup_lim) begin
      in_break = 1'b0;
      pulses = '0;
      reported_lvl = 1'b0;
    end

    if (pulses != '0 && reported_lvl && stable_lvl && !in_break && quiet_age >= gap_lim) begin
      res.digit_done = 1'b1;
      res.digit = (pulses == PULSE_LIMIT) ? '0 : pulses;
      pulses = '0;
    end

    res.raw_off_hook = raw;
    res.off_hook = reported_lvl;
    res.pending_pulses = pulses;
    return res;
  endfunction

  always @(posedge clk) begin
    dial_status_t got;
    dial_status_t want;
    if (rst) begin
      pol_high = 1'b0;
      debounce_lim = 16'd10;
      hangup_lim = 16'd500;
      pulse_lo = 16'd20;
      pulse_hi = 16'd120;
      gap_lim = 16'd300;
      last_raw = 1'b0;
      stable_lvl = 1'b0;
      reported_lvl = 1'b0;
      in_break = 1'b0;
      pulses = '0;
      raw_age = '0;
      break_age = '0;
      quiet_age = '0;
      status_q.delete();
      results_seen = 0;
      fail_count = 0;
    end else begin
      // retire the output transaction before queuing a new sample
      if (dial_out.valid && dial_out.ready) begin
        got.raw_off_hook = dial_out.raw_off_hook;
        got.off_hook = dial_out.off_hook;
        got.pending_pulses = dial_out.pending_pulses;
        got.pulse_event = pulse_event_t'(dial_out.pulse_event);
        got.digit_done = dial_out.digit_done;
        got.digit = dial_out.digit;
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %0d with nothing expected: %s", $realtime, results_seen,
                     status_text(got));
        end else begin
          want = status_q.pop_front();
          if (got.raw_off_hook !== want.raw_off_hook || got.off_hook !== want.off_hook ||
              got.pending_pulses !== want.pending_pulses ||
              got.pulse_event !== want.pulse_event || got.digit_done !== want.digit_done ||
              got.digit !== want.digit) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d mismatch", $realtime, results_seen);
              $display("  expected %s", status_text(want));
              $display("  actual   %s", status_text(got));
            end
          end
        end
        results_seen++;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_HIGH: pol_high = cfg_data[0];
          REG_DEBOUNCE:    debounce_lim = cfg_data;
          REG_HANGUP:      hangup_lim = cfg_data;
          REG_PULSE_MIN:   pulse_lo = cfg_data;
          REG_PULSE_MAX:   pulse_hi = cfg_data;
          REG_DIGIT_GAP:   gap_lim = cfg_data;
          default: ;
        endcase
      end

      if (dial_in.valid && dial_in.ready)
        status_q.push_back(decode_tick(dial_in.hook_level));
    end
    results_due = status_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import rdpd_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = CFG_INDEX_BITS'(6);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = CFG_INDEX_BITS'(7);
  localparam int unsigned TICKS_MAX      = (1 << REG_BITS) - 1;
  localparam int unsigned LONG_HOLD      = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  ticks_t                    cfg_data;
  int unsigned               fail_count;
  int unsigned               results_due;

  // Stimulus-side copies of the timing registers
  logic        pol;
  int unsigned deb_set;
  int unsigned hang_set;
  int unsigned lo_set;
  int unsigned hi_set;
  int unsigned gap_set;

  bit          steady;
  int unsigned lines_sent;

  rdpd_in_if  dial_in ();
  rdpd_out_if dial_out ();

  rotary_dial_pulse_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dial_in   (dial_in),
    .dial_out  (dial_out)
  );

  rdpd_status_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dial_in     (dial_in),
    .dial_out    (dial_out),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sample(input logic lvl);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      dial_in.valid <= 1'b0;
    end
    @(negedge clk);
    dial_in.valid <= 1'b1;
    dial_in.hook_level <= pol ? lvl : ~lvl;
    @(posedge clk);
    while (!dial_in.ready) @(posedge clk);
    lines_sent++;
  endtask

  task automatic hold_line(input logic lvl, input int unsigned n);
    repeat (n) send_sample(lvl);
  endtask

  // Drop valid and wait until every queued status has come back
  task automatic settle();
    @(negedge clk);
    dial_in.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input ticks_t val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACTIVE_HIGH: pol = val[0];
      REG_DEBOUNCE:    deb_set = 32'(val);
      REG_HANGUP:      hang_set = 32'(val);
      REG_PULSE_MIN:   lo_set = 32'(val);
      REG_PULSE_MAX:   hi_set = 32'(val);
      REG_DIGIT_GAP:   gap_set = 32'(val);
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic pol_bit, input int unsigned deb, input int unsigned hang,
                            input int unsigned lo, input int unsigned hi,
                            input int unsigned gap);
    ticks_t polarity_word;
    polarity_word = ticks_t'($urandom);
    polarity_word[0] = pol_bit;
    settle();
    write_reg(REG_ACTIVE_HIGH, polarity_word);
    write_reg(REG_DEBOUNCE, ticks_t'(deb));
    write_reg(REG_HANGUP, ticks_t'(hang));
    write_reg(REG_PULSE_MIN, ticks_t'(lo));
    write_reg(REG_PULSE_MAX, ticks_t'(hi));
    write_reg(REG_DIGIT_GAP, ticks_t'(gap));
  endtask

  // Dialed digits with random pulse timing, mixed with hangups and contact bounce
  task automatic dial_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned n;
    int unsigned brk;
    int unsigned pick;
    stop_at = lines_sent + budget;
    while (lines_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 6)) send_sample(1'($urandom_range(0, 1)));
      end else if (pick < 20) begin
        hold_line(1'b0, hang_set + deb_set + $urandom_range(1, 4));
        hold_line(1'b1, deb_set + $urandom_range(1, 4));
      end else begin
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        hold_line(1'b1, deb_set + 1);
        repeat (n) begin
          if ($urandom_range(0, 4) != 0)
            brk = $urandom_range(lo_set, hi_set);
          else if ($urandom_range(0, 1) == 1 && lo_set > deb_set + 1)
            brk = $urandom_range(deb_set + 1, lo_set - 1);
          else
            brk = hi_set + $urandom_range(1, 4);
          hold_line(1'b0, (brk > deb_set) ? brk : deb_set + 1);
          hold_line(1'b1, deb_set + $urandom_range(1, 4));
        end
        hold_line(1'b1, gap_set + $urandom_range(0, 4));
      end
    end
  endtask

  // Output side back-pressure
  initial begin
    int unsigned stall;
    dial_out.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall != 0) begin
        stall--;
        dial_out.ready <= 1'b0;
      end else begin
        dial_out.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (dial_in.valid && dial_in.ready) || (dial_out.valid && dial_out.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned deb;
    int unsigned lo;
    int unsigned hi;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ACTIVE_HIGH;
    cfg_data = '0;
    dial_in.valid = 1'b0;
    dial_in.hook_level = 1'b0;
    pol = 1'b0;
    deb_set = 10;
    hang_set = 500;
    lo_set = 20;
    hi_set = 120;
    gap_set = 300;
    steady = 1'b0;
    lines_sent = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timing, active-low pin
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);

    // All thresholds zero: off hook, then a break hangs up on its first tick
    set_timing(1'b1, 0, 0, 0, 0, 0);
    write_reg(REG_SPARE_LO, ticks_t'(TICKS_MAX));
    write_reg(REG_SPARE_HI, '0);
    send_sample(1'b1);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);

    // Empty pulse window: every break is ignored
    settle();
    write_reg(REG_HANGUP, ticks_t'(TICKS_MAX));
    send_sample(1'b0);
    send_sample(1'b1);

    // Zero digit gap: digit completes on the pulse tick
    settle();
    write_reg(REG_PULSE_MIN, 16'd1);
    write_reg(REG_PULSE_MAX, ticks_t'(TICKS_MAX));
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);

    settle();
    write_reg(REG_ACTIVE_HIGH, '0);
    send_sample(1'b0);
    send_sample(1'b1);

    // Put the handset on hook, then hold the line with every threshold but the pulse minimum at its top
    set_timing(1'b1, 0, 0, 0, 0, 0);
    send_sample(1'b1);
    send_sample(1'b0);
    steady = 1'b1;
    set_timing(1'b0, TICKS_MAX, TICKS_MAX, 0, TICKS_MAX, TICKS_MAX);
    hold_line(1'b1, LONG_HOLD);
    settle();
    write_reg(REG_DEBOUNCE, '0);
    hold_line(1'b0, 3);
    hold_line(1'b1, LONG_HOLD);
    hold_line(1'b0, LONG_HOLD);
    hold_line(1'b1, 2);

    for (int p = 0; p < 5; p++) begin
      deb = $urandom_range(0, 3);
      lo = deb + $urandom_range(1, 5);
      hi = (p == 4) ? lo : lo + $urandom_range(0, 8);
      set_timing(1'($urandom_range(0, 1)), deb, hi + $urandom_range(2, 25), lo, hi,
                 hi + deb + $urandom_range(6, 14));
      steady = ($urandom_range(0, 3) == 0);
      dial_traffic(40);
    end
    steady = 1'b0;

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== rotary_dial_pulse_decoder.f =====
+incdir+rtl
rtl/rdpd_pkg.sv
rtl/rdpd_in_if.sv
rtl/rdpd_out_if.sv
rtl/rotary_dial_pulse_decoder.sv
dv/rdpd_status_checker.sv
dv/testbench.sv
